### src/cma_pkg.sv
`default_nettype none

package cma_pkg;

  // Storage sizing
  localparam int MAX_POINTS  = 256;
  localparam int SAMPLE_BITS = 16;

  // Field and register widths
  localparam int IDX_W = 8;
  localparam int CNT_W = 9;
  localparam int HW_W  = 7;
  // Window length 2*h+1 with h up to 2^HW_W-1
  localparam int LEN_W = HW_W + 1;
  // Window sum never exceeds (2^LEN_W - 1) samples
  localparam int SUM_W = SAMPLE_BITS + LEN_W;
  localparam int DIV_CNT_W = $clog2(SUM_W);
  localparam int ADDR_W = $clog2(MAX_POINTS);

  // Configuration register map
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 9;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POINT_COUNT = 1'b0,
    CFG_HALF_WIDTH  = 1'b1
  } cfg_reg_t;

  // Input transaction kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic                   kind;
    logic [IDX_W-1:0]       index;
    logic [SAMPLE_BITS-1:0] sample;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0]       index_out;
    logic [SAMPLE_BITS-1:0] average;
    logic                   bad_index;
  } out_t;

endpackage

`default_nettype wire

### src/circular_moving_average.sv
`default_nettype none

// Circular boxcar smoother over a ring of up to 256 Q12.4 samples.
// Input channel (in_valid/in_stall/in_data): a load transaction writes
// in_data.sample at in_data.index; a read transaction returns the mean of the
// 2*h+1 samples centered at the index, wrapping around the ring. Loads at an
// index not below point_count (min 1) are dropped; such reads get bad_index=1.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes point_count
// (index 0) and half_width (index 1); write it only while the block is idle.
// A read issues one window sample per cycle through the single sample RAM
// read port, adds the last sample and hands over to a one-bit-per-cycle
// restoring divider, then moves the result into the output register. A
// bad-index read skips summing and division and goes straight to done.
// in_stall is high while a read is in progress. The result sits in an output
// register; a load may be accepted while it waits, a new read finishes its
// work and then holds in the done state until out_stall lets the previous
// result go. Reset sets point_count to 256 and half_width to 0 and empties
// the output; the sample RAM is not cleared and must be loaded before read.
module circular_moving_average (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire cma_pkg::in_t                   in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output cma_pkg::out_t                       out_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [cma_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cma_pkg::CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SUM  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [cma_pkg::CNT_W-1:0]       point_count_r;
  logic [cma_pkg::HW_W-1:0]        half_width_r;

  logic [cma_pkg::SAMPLE_BITS-1:0] mem [cma_pkg::MAX_POINTS];
  logic [cma_pkg::SAMPLE_BITS-1:0] rd_data_r;

  logic [cma_pkg::ADDR_W-1:0]      pos_r, pos_nxt;
  logic [cma_pkg::LEN_W-1:0]       issue_left_r, issue_left_nxt;
  logic                            rd_pend_r, rd_pend_nxt;
  logic [cma_pkg::LEN_W-1:0]       len_r, len_nxt;
  logic [cma_pkg::CNT_W-1:0]       n_r, n_nxt;
  logic [cma_pkg::SUM_W-1:0]       acc_r, acc_nxt;
  logic [cma_pkg::LEN_W:0]         rem_r, rem_nxt;
  logic [cma_pkg::DIV_CNT_W-1:0]   div_cnt_r, div_cnt_nxt;
  logic [cma_pkg::IDX_W-1:0]       res_idx_r, res_idx_nxt;
  logic                            res_bad_r, res_bad_nxt;

  logic                            out_valid_r, out_valid_nxt;
  cma_pkg::out_t                   out_data_r, out_data_nxt;

  logic                            in_acc, out_take, mem_we;
  logic [cma_pkg::CNT_W-1:0]       n_eff;
  logic [cma_pkg::HW_W-1:0]        h_eff;
  logic                            bad;
  logic [cma_pkg::CNT_W-1:0]       start_pos, pos_inc;
  logic [cma_pkg::LEN_W:0]         trial;

  // Configuration port always ready; user must write it while idle, not enforced
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= cma_pkg::CNT_W'(cma_pkg::MAX_POINTS);
      half_width_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cma_pkg::cfg_reg_t'(cfg_index))
        cma_pkg::CFG_POINT_COUNT: point_count_r <= cfg_data[cma_pkg::CNT_W-1:0];
        cma_pkg::CFG_HALF_WIDTH:  half_width_r  <= cfg_data[cma_pkg::HW_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective ring size and window half width
  always_comb begin
    if (point_count_r == '0) begin
      n_eff = cma_pkg::CNT_W'(1);
    end else if (point_count_r > cma_pkg::CNT_W'(cma_pkg::MAX_POINTS)) begin
      n_eff = cma_pkg::CNT_W'(cma_pkg::MAX_POINTS);
    end else begin
      n_eff = point_count_r;
    end
    if ({{(cma_pkg::CNT_W-cma_pkg::HW_W){1'b0}}, half_width_r} > n_eff - 1'b1) begin
      h_eff = (n_eff - 1'b1) >= cma_pkg::CNT_W'(1 << cma_pkg::HW_W)
            ? '1 : cma_pkg::HW_W'(n_eff - 1'b1);
    end else begin
      h_eff = half_width_r;
    end
  end

  assign bad = {{(cma_pkg::CNT_W-cma_pkg::IDX_W){1'b0}}, in_data.index} >= n_eff;

  // First window position: index - h, wrapped once
  always_comb begin
    if (in_data.index >= {{(cma_pkg::IDX_W-cma_pkg::HW_W){1'b0}}, h_eff}) begin
      start_pos = cma_pkg::CNT_W'(in_data.index) - cma_pkg::CNT_W'(h_eff);
    end else begin
      start_pos = cma_pkg::CNT_W'(in_data.index) + n_eff - cma_pkg::CNT_W'(h_eff);
    end
  end

  assign pos_inc  = cma_pkg::CNT_W'(pos_r) + 1'b1;
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_take = out_valid_r && !out_stall;
  assign mem_we   = in_acc && (in_data.kind == cma_pkg::KIND_LOAD) && !bad;

  // Sample RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[in_data.index[cma_pkg::ADDR_W-1:0]] <= in_data.sample;
    end
    if (state_r == ST_SUM && issue_left_r != '0) begin
      rd_data_r <= mem[pos_r];
    end
  end

  // Divider trial subtraction
  assign trial = {rem_r[cma_pkg::LEN_W-1:0], acc_r[cma_pkg::SUM_W-1]};

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    pos_nxt        = pos_r;
    issue_left_nxt = issue_left_r;
    rd_pend_nxt    = 1'b0;
    len_nxt        = len_r;
    n_nxt          = n_r;
    acc_nxt        = acc_r;
    rem_nxt        = rem_r;
    div_cnt_nxt    = div_cnt_r;
    res_idx_nxt    = res_idx_r;
    res_bad_nxt    = res_bad_r;
    out_valid_nxt  = out_take ? 1'b0 : out_valid_r;
    out_data_nxt   = out_data_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_data.kind == cma_pkg::KIND_READ) begin
          res_idx_nxt    = in_data.index;
          res_bad_nxt    = bad;
          pos_nxt        = start_pos[cma_pkg::ADDR_W-1:0];
          len_nxt        = {h_eff, 1'b1};
          issue_left_nxt = {h_eff, 1'b1};
          n_nxt          = n_eff;
          acc_nxt        = '0;
          rem_nxt        = '0;
          state_nxt      = bad ? ST_DONE : ST_SUM;
        end
      end
      ST_SUM: begin
        // One RAM read issued per cycle, accumulated in the following cycle
        if (issue_left_r != '0) begin
          issue_left_nxt = issue_left_r - 1'b1;
          rd_pend_nxt    = 1'b1;
          pos_nxt        = (pos_inc == n_r) ? '0 : pos_inc[cma_pkg::ADDR_W-1:0];
        end
        if (rd_pend_r) begin
          acc_nxt = acc_r + cma_pkg::SUM_W'(rd_data_r);
        end
        if (issue_left_r == '0 && !rd_pend_r) begin
          div_cnt_nxt = cma_pkg::DIV_CNT_W'(cma_pkg::SUM_W - 1);
          state_nxt   = ST_DIV;
        end
      end
      ST_DIV: begin
        // Restoring division, one quotient bit per cycle into acc
        if (trial >= {1'b0, len_r}) begin
          rem_nxt = trial - {1'b0, len_r};
          acc_nxt = {acc_r[cma_pkg::SUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial;
          acc_nxt = {acc_r[cma_pkg::SUM_W-2:0], 1'b0};
        end
        div_cnt_nxt = div_cnt_r - 1'b1;
        if (div_cnt_r == '0) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // Wait for the output register to be free
        if (!out_valid_r || out_take) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.index_out = res_idx_r;
          out_data_nxt.average   = res_bad_r ? '0 : acc_r[cma_pkg::SAMPLE_BITS-1:0];
          out_data_nxt.bad_index = res_bad_r;
          state_nxt              = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rd_pend_r    <= 1'b0;
      issue_left_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rd_pend_r    <= rd_pend_nxt;
      issue_left_r <= issue_left_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    len_r      <= len_nxt;
    n_r        <= n_nxt;
    acc_r      <= acc_nxt;
    rem_r      <= rem_nxt;
    div_cnt_r  <= div_cnt_nxt;
    res_idx_r  <= res_idx_nxt;
    res_bad_r  <= res_bad_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // Bad-index read skips summing and division
  a_bad_skips: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.kind == cma_pkg::KIND_READ && bad |=> state_r == ST_DONE)
    else $error("bad-index read did not go straight to done");

  // Summing ends once all reads are issued and returned
  a_sum_ends: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SUM && issue_left_r == '0 && !rd_pend_r |=> state_r == ST_DIV)
    else $error("summing did not hand over to the divider");

  // After division the remainder is below the window length
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE && !res_bad_r |-> rem_r < {1'b0, len_r})
    else $error("divider remainder out of range");

  // The mean never exceeds a sample, so the quotient fits the output field
  a_quot_fits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE && !res_bad_r |-> acc_r[cma_pkg::SUM_W-1:cma_pkg::SAMPLE_BITS] == '0)
    else $error("window mean overflows the sample width");

  // A load never starts the sequencer
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.kind == cma_pkg::KIND_LOAD |=> state_r == ST_IDLE)
    else $error("load transaction left the idle state");
`endif

endmodule

`default_nettype wire
